@@ rtl/assert_macros.svh @@
//----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the timer RTL.
//----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock and quiet during reset.
`define SMT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed in shared counter match timer");

// Next-cycle implication, clocked on clock and quiet during reset.
`define SMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed in shared counter match timer");

`endif

@@ rtl/smt_pkg.sv @@
//----------------------------------------------------------------------------
// Shared counter match timer package
// Types, widths and register indexes shared by the timer files.
//----------------------------------------------------------------------------
package smt_pkg;

   localparam int CHANNELS_DEF   = 2;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed field widths.
   localparam int MASK_W   = 2;
   localparam int PERIOD_W = 16;
   localparam int PRESC_W  = 16;
   localparam int COUNT_W  = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_ARM    = 2'd1,
      REQ_DISARM = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESCALE_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_CHAN0   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_CHAN1   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD_MODE    = 8'd3;

   // Per-channel command for one processed item.
   typedef struct packed {
      logic advance;   // counter steps onto a new value this cycle
      logic arm;
      logic disarm;
      logic clear;
   } chan_cmd_type;

endpackage

@@ rtl/smt_ifaces.sv @@
//----------------------------------------------------------------------------
// Shared counter match timer channel interfaces
// Valid/ready interfaces for requests, results and register writes.
//----------------------------------------------------------------------------
interface smt_req_if;
   logic                      valid;
   logic                      ready;
   smt_pkg::req_kind_type     req_type;
   logic                      channel;

   modport source (output valid, req_type, channel, input ready);
   modport sink   (input valid, req_type, channel, output ready);
endinterface

interface smt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [smt_pkg::MASK_W-1:0]         expired_mask;
   logic [smt_pkg::MASK_W-1:0]         timeout_flags;
   logic [smt_pkg::MASK_W-1:0]         armed_mask;
   logic [smt_pkg::COUNT_W-1:0]        count_value;

   modport source (output valid, expired_mask, timeout_flags, armed_mask, count_value,
                   input ready);
   modport sink   (input valid, expired_mask, timeout_flags, armed_mask, count_value,
                   output ready);
endinterface

interface smt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [smt_pkg::CSR_IDX_W-1:0]      index;
   logic [smt_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/shared_counter_match_timer.sv @@
//----------------------------------------------------------------------------
// Shared counter match timer
// Compare-match timer channels with auto-reload over one prescaled counter.
//----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   req_bus   in         valid/ready    req_type, channel
//   rsp_bus   out        valid/ready    expired_mask, timeout_flags, armed_mask,
//                                       count_value
//   csr_bus   in         valid/ready    index, data (always ready)
//
// Each item waits in the input register and is processed as it moves into
// the result register; one item is taken every cycle while the result side
// keeps up, since the counter, prescaler and channel compares all update as
// the item moves. Reset is synchronous and clears the counter, prescaler,
// channels, configuration registers and both valid bits. A stalled result
// holds both stages; req_bus.ready drops only when both the input and result
// registers are full.
//----------------------------------------------------------------------------
`include "assert_macros.svh"

module shared_counter_match_timer #(
   parameter int CHANNELS   = smt_pkg::CHANNELS_DEF,
   parameter int COUNT_BITS = smt_pkg::COUNT_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   smt_req_if.sink  req_bus,
   smt_rsp_if.source rsp_bus,
   smt_csr_if.sink  csr_bus
);

   localparam int MW = smt_pkg::MASK_W;

   // Configuration registers.
   logic [smt_pkg::PRESC_W-1:0]  presc_limit_ff;
   logic [smt_pkg::PERIOD_W-1:0] period_ff [MW];
   logic [MW-1:0]                reload_ff;

   // Timebase.
   logic [smt_pkg::PRESC_W-1:0]  presc_ff, presc_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;

   // Input register.
   logic                         s1_valid_ff, s1_valid_in;
   smt_pkg::req_kind_type        s1_kind_ff;
   logic                         s1_chan_ff;

   // Result register.
   logic                         out_valid_ff, out_valid_in;
   logic [MW-1:0]                out_expired_ff, out_timeout_ff, out_armed_ff;
   logic [smt_pkg::COUNT_W-1:0]  out_count_ff;

   logic                         out_free, fire, tick, roll, advance, chan_ok;
   logic [MW-1:0]                exp_mask, armed_mask, timeout_mask;
   logic [smt_pkg::COUNT_W-1:0]  count_view;

   //-------------------------------------------------------------------------
   // Register writes. Configuration must only be changed while the timer is idle;
   // the block does not enforce this, and the port never stalls.
   //-------------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_limit_ff <= '0;
         period_ff      <= '{default: '0};
         reload_ff      <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            smt_pkg::CSR_PRESCALE_LIMIT: presc_limit_ff <= csr_bus.data;
            smt_pkg::CSR_PERIOD_CHAN0:   period_ff[0]   <= csr_bus.data;
            smt_pkg::CSR_PERIOD_CHAN1:   period_ff[1]   <= csr_bus.data;
            smt_pkg::CSR_RELOAD_MODE:    reload_ff      <= csr_bus.data[MW-1:0];
            default: begin
               // Indexes beyond the register list are dropped.
            end
         endcase
      end
   end

   //-------------------------------------------------------------------------
   // Handshake. An item in the input register is processed in the cycle it
   // moves into the result register, which is when the result register is
   // empty or being drained.
   //-------------------------------------------------------------------------
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;

   assign s1_valid_in  = (req_bus.valid && req_bus.ready) ? 1'b1 :
                         (fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_kind_ff <= req_bus.req_type;
         s1_chan_ff <= req_bus.channel;
      end
   end

   //-------------------------------------------------------------------------
   // Prescaler and shared counter. A tick either steps the prescaler or, once
   // it has reached the limit (or passed a lowered limit), wraps it to zero
   // and advances the counter.
   //-------------------------------------------------------------------------
   assign tick    = fire && (s1_kind_ff == smt_pkg::REQ_TICK);
   assign roll    = presc_ff >= presc_limit_ff;
   assign advance = tick && roll;

   always_comb begin
      presc_in = presc_ff;
      count_in = count_ff;
      if (tick) begin
         if (roll) begin
            presc_in = '0;
            count_in = count_ff + 1'b1;
         end else begin
            presc_in = presc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff <= '0;
         count_ff <= '0;
      end else begin
         presc_ff <= presc_in;
         count_ff <= count_in;
      end
   end

   //-------------------------------------------------------------------------
   // Channels. Requests naming a channel that is not built are ignored.
   //-------------------------------------------------------------------------
   assign chan_ok = int'(s1_chan_ff) < CHANNELS;

   generate
      for (genvar c = 0; c < MW; c++) begin : g_chan
         if (c < CHANNELS) begin : g_used
            smt_pkg::chan_cmd_type cmd;
            logic                  sel;

            assign sel         = fire && chan_ok && (s1_chan_ff == 1'(c));
            assign cmd.advance = advance;
            assign cmd.arm     = sel && (s1_kind_ff == smt_pkg::REQ_ARM);
            assign cmd.disarm  = sel && (s1_kind_ff == smt_pkg::REQ_DISARM);
            assign cmd.clear   = sel && (s1_kind_ff == smt_pkg::REQ_CLEAR);

            smt_channel #(
               .COUNT_BITS (COUNT_BITS)
            ) u_chan (
               .clock        (clock),
               .reset        (reset),
               .cmd          (cmd),
               .count_cur    (count_ff),
               .count_new    (count_in),
               .period       (period_ff[c]),
               .reload       (reload_ff[c]),
               .expired      (exp_mask[c]),
               .armed_next   (armed_mask[c]),
               .timeout_next (timeout_mask[c])
            );
         end else begin : g_unused
            assign exp_mask[c]     = 1'b0;
            assign armed_mask[c]   = 1'b0;
            assign timeout_mask[c] = 1'b0;
         end
      end
   endgenerate

   // The reported count is the low 16 bits of the updated counter, zero-extended if narrower.
   generate
      if (COUNT_BITS >= smt_pkg::COUNT_W) begin : g_view_wide
         assign count_view = count_in[smt_pkg::COUNT_W-1:0];
      end else begin : g_view_narrow
         assign count_view = {{(smt_pkg::COUNT_W-COUNT_BITS){1'b0}}, count_in};
      end
   endgenerate

   //-------------------------------------------------------------------------
   // Result register.
   //-------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (fire) begin
         out_expired_ff <= exp_mask;
         out_timeout_ff <= timeout_mask;
         out_armed_ff   <= armed_mask;
         out_count_ff   <= count_view;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.expired_mask  = out_expired_ff;
   assign rsp_bus.timeout_flags = out_timeout_ff;
   assign rsp_bus.armed_mask    = out_armed_ff;
   assign rsp_bus.count_value   = out_count_ff;

   `SMT_ASSERT_NOW(a_expiry_needs_advance, exp_mask != '0, advance)
   `SMT_ASSERT_NEXT(a_roll_clears_prescaler, advance, presc_ff == '0)
   `SMT_ASSERT_NOW(a_ready_when_result_empty, !out_valid_ff, req_bus.ready)

endmodule

@@ rtl/smt_channel.sv @@
//----------------------------------------------------------------------------
// Timer compare channel
// Match value, armed bit and sticky timeout flag of one channel.
//----------------------------------------------------------------------------
`include "assert_macros.svh"

module smt_channel #(
   parameter int COUNT_BITS = smt_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  smt_pkg::chan_cmd_type        cmd,
   input  logic [COUNT_BITS-1:0]        count_cur,
   input  logic [COUNT_BITS-1:0]        count_new,
   input  logic [smt_pkg::PERIOD_W-1:0] period,
   input  logic                         reload,
   output logic                         expired,
   output logic                         armed_next,
   output logic                         timeout_next
);

   logic [COUNT_BITS-1:0] period_ext;
   logic [COUNT_BITS-1:0] match_ff, match_in;
   logic                  armed_ff, armed_in;
   logic                  timeout_ff, timeout_in;

   // The period is taken modulo the counter width.
   generate
      if (COUNT_BITS > smt_pkg::PERIOD_W) begin : g_period_wide
         assign period_ext = {{(COUNT_BITS-smt_pkg::PERIOD_W){1'b0}}, period};
      end else begin : g_period_narrow
         assign period_ext = period[COUNT_BITS-1:0];
      end
   endgenerate

   assign expired = cmd.advance && armed_ff && (match_ff == count_new);

   always_comb begin
      match_in   = match_ff;
      armed_in   = armed_ff;
      timeout_in = timeout_ff;
      priority if (expired) begin
         timeout_in = 1'b1;
         if (reload) begin
            match_in = match_ff + period_ext;
         end else begin
            armed_in = 1'b0;
         end
      end else if (cmd.arm) begin
         match_in   = count_cur + period_ext;
         armed_in   = 1'b1;
         timeout_in = 1'b0;
      end else if (cmd.disarm) begin
         armed_in = 1'b0;
      end else if (cmd.clear) begin
         timeout_in = 1'b0;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff   <= '0;
         armed_ff   <= 1'b0;
         timeout_ff <= 1'b0;
      end else begin
         match_ff   <= match_in;
         armed_ff   <= armed_in;
         timeout_ff <= timeout_in;
      end
   end

   assign armed_next   = armed_in;
   assign timeout_next = timeout_in;

   `SMT_ASSERT_NEXT(a_expiry_sets_flag, expired, timeout_ff)
   `SMT_ASSERT_NEXT(a_oneshot_disarms, expired && !reload, !armed_ff)
   `SMT_ASSERT_NEXT(a_arm_state, cmd.arm && !cmd.advance, armed_ff && !timeout_ff)

endmodule

@@ sim/shared_counter_match_timer_tb.sv @@
`timescale 1ns / 100ps
//----------------------------------------------------------------------------
// Shared counter match timer testbench
// Drives request items through the timer under several register settings,
// predicts every result item from its own model of the prescaler, counter
// and channels, and compares each result field by field.
//----------------------------------------------------------------------------
module shared_counter_match_timer_tb;

   // Register indexes past the end of the register list; writes are ignored.
   localparam logic [smt_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_FIRST = 8'd4;
   localparam logic [smt_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LAST  = 8'hFF;

   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 113;
   localparam int HOLD_CYCLES     = 200;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct packed {
      smt_pkg::req_kind_type kind;
      logic                  chan;
   } timer_req_type;

   typedef struct packed {
      logic [smt_pkg::MASK_W-1:0]  expired;
      logic [smt_pkg::MASK_W-1:0]  flags;
      logic [smt_pkg::MASK_W-1:0]  armed;
      logic [smt_pkg::COUNT_W-1:0] count;
   } timer_result_type;

   logic clock;
   logic reset;

   smt_req_if req_bus ();
   smt_rsp_if rsp_bus ();
   smt_csr_if csr_bus ();

   shared_counter_match_timer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Stimulus waiting to be offered and results waiting to arrive.
   timer_req_type    pending_reqs[$];
   timer_result_type expected_results[$];

   // Predicted register contents.
   logic [smt_pkg::PRESC_W-1:0]  presc_limit;
   logic [smt_pkg::PERIOD_W-1:0] chan_period [2];
   logic [1:0]                   reload_bits;

   // Predicted timer state.
   logic [smt_pkg::PRESC_W-1:0]  presc_count;
   logic [smt_pkg::COUNT_W-1:0]  tick_count;
   logic [smt_pkg::COUNT_W-1:0]  chan_match [2];
   logic [1:0]                   chan_armed;
   logic [1:0]                   chan_timeout;

   // Idle percentages for each side and the long receiver hold-off.
   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold_arm;
   logic hold_done;
   int   hold_left;

   int errors;
   int results_checked;
   int expiries_seen;
   int settings_used;

   always #5 clock = ~clock;

   //-------------------------------------------------------------------------
   // Mismatch reporting: one line per failure, and a running count.
   //-------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
   endtask

   //-------------------------------------------------------------------------
   // Register write as seen by the predictor. Only the low bits that a
   // register holds are kept, and indexes past the list change nothing.
   //-------------------------------------------------------------------------
   task automatic apply_register(input logic [smt_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [smt_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         smt_pkg::CSR_PRESCALE_LIMIT: presc_limit = value;
         smt_pkg::CSR_PERIOD_CHAN0:   chan_period[0] = value;
         smt_pkg::CSR_PERIOD_CHAN1:   chan_period[1] = value;
         smt_pkg::CSR_RELOAD_MODE:    reload_bits = value[1:0];
         default: ;
      endcase
   endtask

   //-------------------------------------------------------------------------
   // Timer prediction for one accepted request item. The compare is made
   // only when the counter advances, against the new counter value.
   //-------------------------------------------------------------------------
   task automatic advance_timer(input smt_pkg::req_kind_type kind, input logic chan);
      timer_result_type res;
      logic [1:0]       fired;
      fired = '0;
      case (kind)
         smt_pkg::REQ_TICK: begin
            if (presc_count >= presc_limit) begin
               // A lowered limit also lands here, which restarts the divider.
               presc_count = '0;
               tick_count  = tick_count + 1'b1;
               for (int c = 0; c < 2; c++) begin
                  if (chan_armed[c] && chan_match[c] == tick_count) begin
                     fired[c]        = 1'b1;
                     chan_timeout[c] = 1'b1;
                     if (reload_bits[c])
                        chan_match[c] = chan_match[c] + chan_period[c];
                     else
                        chan_armed[c] = 1'b0;
                  end
               end
            end else begin
               presc_count = presc_count + 1'b1;
            end
         end
         smt_pkg::REQ_ARM: begin
            // Arming an armed channel simply reloads its match.
            chan_match[chan]   = tick_count + chan_period[chan];
            chan_armed[chan]   = 1'b1;
            chan_timeout[chan] = 1'b0;
         end
         smt_pkg::REQ_DISARM: chan_armed[chan] = 1'b0;
         smt_pkg::REQ_CLEAR:  chan_timeout[chan] = 1'b0;
         default: ;
      endcase
      res.expired = fired;
      res.flags   = chan_timeout;
      res.armed   = chan_armed;
      res.count   = tick_count;
      expected_results.push_back(res);
   endtask

   //-------------------------------------------------------------------------
   // Request driver. An offered item is held until it is taken; the model
   // is advanced at the edge where it is accepted. Idle gaps are only
   // inserted between items, never while one is being offered.
   //-------------------------------------------------------------------------
   always @(posedge clock) begin
      timer_req_type nxt;
      logic          offering;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         offering = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            advance_timer(req_bus.req_type, req_bus.channel);
            offering = 1'b0;
         end
         if (!offering) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.req_type <= nxt.kind;
               req_bus.channel  <= nxt.chan;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   //-------------------------------------------------------------------------
   // Long receiver hold-off. Once armed, result ready stays low for a fixed
   // stretch so that both stages of the block fill and its input stalls
   // while the driver keeps offering items.
   //-------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   //-------------------------------------------------------------------------
   // Result monitor. Every accepted result is checked against the oldest
   // prediction; a result with nothing predicted is a failure of its own.
   //-------------------------------------------------------------------------
   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result item", rsp_bus.count_value, 0);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               expiries_seen += $countones(want.expired);
               if (rsp_bus.expired_mask !== want.expired)
                  report_mismatch("expired_mask", rsp_bus.expired_mask, want.expired);
               if (rsp_bus.timeout_flags !== want.flags)
                  report_mismatch("timeout_flags", rsp_bus.timeout_flags, want.flags);
               if (rsp_bus.armed_mask !== want.armed)
                  report_mismatch("armed_mask", rsp_bus.armed_mask, want.armed);
               if (rsp_bus.count_value !== want.count)
                  report_mismatch("count_value", rsp_bus.count_value, want.count);
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   //-------------------------------------------------------------------------
   // Stimulus helpers.
   //-------------------------------------------------------------------------
   task automatic queue_req(input smt_pkg::req_kind_type kind, input logic chan);
      timer_req_type item;
      item.kind = kind;
      item.chan = chan;
      pending_reqs.push_back(item);
   endtask

   // Mostly ticks so that armed channels actually reach their match, with
   // arms, disarms and clears sprinkled in at random.
   task automatic queue_random_req();
      int roll;
      smt_pkg::req_kind_type kind;
      roll = $urandom_range(99);
      if (roll < 68)
         kind = smt_pkg::REQ_TICK;
      else if (roll < 84)
         kind = smt_pkg::REQ_ARM;
      else if (roll < 92)
         kind = smt_pkg::REQ_DISARM;
      else
         kind = smt_pkg::REQ_CLEAR;
      queue_req(kind, 1'($urandom_range(1)));
   endtask

   // Register write over the configuration channel; the predictor takes
   // the new value at the edge where the write is accepted. Valid stays
   // high into the next write of a burst and is dropped by write_settings.
   task automatic write_register(input logic [smt_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [smt_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      apply_register(idx, value);
   endtask

   task automatic write_settings(input logic [15:0] presc, input logic [15:0] per0,
                                 input logic [15:0] per1, input logic [15:0] mode);
      write_register(smt_pkg::CSR_PRESCALE_LIMIT, presc);
      write_register(smt_pkg::CSR_PERIOD_CHAN0, per0);
      write_register(smt_pkg::CSR_PERIOD_CHAN1, per1);
      write_register(smt_pkg::CSR_RELOAD_MODE, mode);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Waits until every item has been taken and every result has arrived,
   // then lets the pipeline drain so that it is surely empty.
   task automatic wait_until_idle();
      @(posedge clock);
      while (pending_reqs.size() > 0 || req_bus.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_period();
      int roll;
      roll = $urandom_range(19);
      if (roll == 0)
         return 16'd0;
      else if (roll == 1)
         return 16'hFFFF;
      else
         return 16'($urandom_range(24, 1));
   endfunction

   //-------------------------------------------------------------------------
   // Main sequence.
   //-------------------------------------------------------------------------
   initial begin
      logic [15:0] presc;
      clock            = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = smt_pkg::REQ_TICK;
      req_bus.channel  = 1'b0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      hold_arm         = 1'b0;
      send_idle_pct    = 23;
      recv_idle_pct    = 64;
      errors           = 0;
      results_checked  = 0;
      expiries_seen    = 0;
      settings_used    = 0;

      // The model starts from the reset state of the block.
      presc_limit  = '0;
      chan_period  = '{default: '0};
      reload_bits  = '0;
      presc_count  = '0;
      tick_count   = '0;
      chan_match   = '{default: '0};
      chan_armed   = '0;
      chan_timeout = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first setting: writes past the register list must be
      // ignored, then channel zero auto-reloads with a short period and
      // channel one is one-shot. The reload mode write carries junk in its
      // upper bits.
      write_register(CSR_UNMAPPED_FIRST, 16'hFFFF);
      write_register(CSR_UNMAPPED_LAST, 16'h1234);
      write_settings(16'd0, 16'd3, 16'd5, 16'hFFFD);
      queue_req(smt_pkg::REQ_ARM, 1'b0);
      queue_req(smt_pkg::REQ_ARM, 1'b1);
      repeat (6) queue_req(smt_pkg::REQ_TICK, 1'b1);
      queue_req(smt_pkg::REQ_CLEAR, 1'b1);
      queue_req(smt_pkg::REQ_DISARM, 1'b0);
      queue_req(smt_pkg::REQ_TICK, 1'b0);
      queue_req(smt_pkg::REQ_ARM, 1'b0);
      queue_req(smt_pkg::REQ_TICK, 1'b0);
      // Re-arming an armed channel restarts its period from the counter.
      queue_req(smt_pkg::REQ_ARM, 1'b0);
      repeat (3) queue_req(smt_pkg::REQ_TICK, 1'b1);
      wait_until_idle();

      // Directed part, second setting: slow prescaler, period zero and the
      // largest period, both channels auto-reload.
      write_settings(16'd3, 16'd0, 16'hFFFF, 16'd3);
      queue_req(smt_pkg::REQ_ARM, 1'b0);
      queue_req(smt_pkg::REQ_ARM, 1'b1);
      repeat (2) queue_req(smt_pkg::REQ_TICK, 1'b0);
      wait_until_idle();

      // The prescaler is now above the new limit, so the next tick advances
      // the counter and restarts the divider.
      write_settings(16'd1, 16'd2, 16'd1, 16'd0);
      repeat (3) queue_req(smt_pkg::REQ_TICK, 1'b0);
      queue_req(smt_pkg::REQ_DISARM, 1'b1);
      queue_req(smt_pkg::REQ_CLEAR, 1'b0);
      wait_until_idle();

      // Random part. The first third idles the sender lightly and the
      // receiver heavily, the second third the other way round, and the last
      // third runs flat out with one long receiver hold-off at its start.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: presc = 16'd0;
            1: presc = 16'd1;
            2: presc = 16'hFFFF;
            3: presc = 16'd0;
            4: presc = 16'($urandom_range(3));
            default: presc = 16'd2;
         endcase
         if (ph < 2) begin
            send_idle_pct = 23;
            recv_idle_pct = 64;
         end else if (ph < 4) begin
            send_idle_pct = 64;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_settings(presc, pick_period(), pick_period(),
                        (ph == 1) ? 16'd3 : (ph == 3) ? 16'd0 : 16'($urandom));
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            queue_random_req();
         if (ph == 4)
            hold_arm <= 1'b1;
         wait_until_idle();
      end

      repeat (10) @(posedge clock);
      $display("Checked %0d result items over %0d register settings, %0d channel expiries.",
               results_checked, settings_used, expiries_seen);
      $display("Covered tick, arm, re-arm, disarm and clear on both channels, %s",
               "a lowered prescaler, a long output stall and unmapped register writes.");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (expected_results.size() != 0)
            $display("%0d predicted result items never arrived", expected_results.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timed out with %0d result items outstanding", expected_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
